// File: src/fpa_pkg.sv
// Shared constants, payload types and the saturation helper for the Q24.8 fixed-point ALU.
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int MULQ_W    = PROD_W - FRAC_BITS + 1;
    localparam int DIV_CELLS = NUM_W;

    localparam logic [3:0] KIND_ADD    = 4'd0;
    localparam logic [3:0] KIND_SUB    = 4'd1;
    localparam logic [3:0] KIND_MUL    = 4'd2;
    localparam logic [3:0] KIND_DIV    = 4'd3;
    localparam logic [3:0] KIND_MIN    = 4'd4;
    localparam logic [3:0] KIND_MAX    = 4'd5;
    localparam logic [3:0] KIND_INC    = 4'd6;
    localparam logic [3:0] KIND_DEC    = 4'd7;
    localparam logic [3:0] KIND_TO_INT = 4'd8;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_OVF  = 2'd1;
    localparam logic [1:0] FAULT_DIV0 = 2'd2;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [3:0]               kind;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     a_greater;
        logic                     a_equal;
        logic                     a_less;
        logic [1:0]               fault;
    } t_out_item;

    // Everything an item carries along the whole pipeline.
    typedef struct packed {
        logic [3:0]        kind;
        logic              gt;
        logic              eq;
        logic              lt;
        logic [DATA_W-1:0] simple_result;
        logic [1:0]        simple_fault;
        logic              neg;
        logic              div_zero;
        logic              a_neg;
    } t_common;

    typedef struct packed {
        t_common           common;
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
    } t_prep;

    typedef struct packed {
        t_common           common;
        logic [PROD_W-1:0] product;
        logic [DATA_W-1:0] den;
        logic [DATA_W-1:0] rem;
        logic [NUM_W-1:0]  nq;
    } t_cell;

    typedef struct packed {
        t_common           common;
        logic [NUM_W:0]    q_rnd;
        logic [MULQ_W-1:0] m_rnd;
    } t_fin;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [1:0]        fault;
    } t_sat;

    // Applies a sign to a magnitude and saturates it to the signed data range.
    function automatic t_sat sat_mag(input logic neg, input logic [PROD_W-1:0] mag);
        t_sat res;
        res.fault = FAULT_NONE;
        if (neg) begin
            if (mag > PROD_W'(SAT_MIN)) begin
                res.value = SAT_MIN;
                res.fault = FAULT_OVF;
            end else begin
                res.value = ~mag[DATA_W-1:0] + {{(DATA_W-1){1'b0}}, 1'b1};
            end
        end else begin
            if (mag > PROD_W'(SAT_MAX)) begin
                res.value = SAT_MAX;
                res.fault = FAULT_OVF;
            end else begin
                res.value = mag[DATA_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

// File: src/fpa_prep.sv
// Input stage: compare flags, the simple operations and operand magnitudes.
module fpa_prep import fpa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in_item i_data,
    output logic     o_valid,
    output t_prep    o_data
);

    logic              r_valid;
    t_prep             r_data;
    t_prep             n_data;
    logic [DATA_W-1:0] ua;
    logic [DATA_W-1:0] ub;
    logic [DATA_W:0]   opb;
    logic              cin;
    logic [DATA_W:0]   sum;
    logic              ovf;
    logic [DATA_W-1:0] sum_sat;
    logic              gt;
    logic              lt;

    assign ua = i_data.operand_a;
    assign ub = i_data.operand_b;
    assign gt = i_data.operand_a > i_data.operand_b;
    assign lt = i_data.operand_a < i_data.operand_b;

    // One 33-bit adder serves add, subtract, increment and decrement.
    always_comb begin
        opb = {ub[DATA_W-1], ub};
        cin = 1'b0;
        case (i_data.kind)
            KIND_SUB: begin
                opb = ~{ub[DATA_W-1], ub};
                cin = 1'b1;
            end
            KIND_INC: opb = {{DATA_W{1'b0}}, 1'b1};
            KIND_DEC: opb = {(DATA_W+1){1'b1}};
            default:  opb = {ub[DATA_W-1], ub};
        endcase
    end

    assign sum     = {ua[DATA_W-1], ua} + opb + {{DATA_W{1'b0}}, cin};
    assign ovf     = sum[DATA_W] ^ sum[DATA_W-1];
    assign sum_sat = sum[DATA_W] ? SAT_MIN : SAT_MAX;

    always_comb begin
        n_data.common.kind     = i_data.kind;
        n_data.common.gt       = gt;
        n_data.common.eq       = (ua == ub);
        n_data.common.lt       = lt;
        n_data.common.neg      = ua[DATA_W-1] ^ ub[DATA_W-1];
        n_data.common.div_zero = (ub == '0);
        n_data.common.a_neg    = ua[DATA_W-1];
        n_data.mag_a = ua[DATA_W-1] ? (~ua + {{(DATA_W-1){1'b0}}, 1'b1}) : ua;
        n_data.mag_b = ub[DATA_W-1] ? (~ub + {{(DATA_W-1){1'b0}}, 1'b1}) : ub;
        n_data.common.simple_fault = FAULT_NONE;
        case (i_data.kind)
            KIND_ADD, KIND_SUB, KIND_INC, KIND_DEC: begin
                if (ovf) begin
                    n_data.common.simple_result = sum_sat;
                    n_data.common.simple_fault  = FAULT_OVF;
                end else begin
                    n_data.common.simple_result = sum[DATA_W-1:0];
                end
            end
            KIND_MIN:    n_data.common.simple_result = lt ? ua : ub;
            KIND_MAX:    n_data.common.simple_result = gt ? ua : ub;
            KIND_TO_INT: n_data.common.simple_result = i_data.operand_a >>> FRAC_BITS;
            default:     n_data.common.simple_result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: src/fpa_mul.sv
// Magnitude product stage; also seeds the division chain.
module fpa_mul import fpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_prep i_data,
    output logic  o_valid,
    output t_cell o_data
);

    logic              r_valid;
    t_cell             r_data;
    t_cell             n_data;
    logic [PROD_W-1:0] product;

    assign product = i_data.mag_a * i_data.mag_b;

    always_comb begin
        n_data.common  = i_data.common;
        n_data.product = product;
        n_data.den     = i_data.mag_b;
        n_data.rem     = '0;
        n_data.nq      = {i_data.mag_a, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: src/fpa_div_cell.sv
// One restoring-division cell: produces one quotient bit and passes the item on.
module fpa_div_cell import fpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_cell i_data,
    output logic  o_valid,
    output t_cell o_data
);

    logic            r_valid;
    t_cell           r_data;
    t_cell           n_data;
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic            ge;

    // Bring down the next numerator bit and try to subtract the divisor.
    assign trial = {i_data.rem, i_data.nq[NUM_W-1]};
    assign diff  = trial - {1'b0, i_data.den};
    assign ge    = (trial >= {1'b0, i_data.den});

    always_comb begin
        n_data     = i_data;
        n_data.rem = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        n_data.nq  = {i_data.nq[NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.den != '0) |-> (r_data.rem < r_data.den))
        else $error("division remainder not below divisor");

endmodule

// File: src/fpa_finish.sv
// Two output stages: rounding of product and quotient, then saturation and selection.
module fpa_finish import fpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_cell     i_data,
    output logic      o_valid,
    output t_out_item o_data
);

    logic      r_valid_1;
    t_fin      r_fin;
    t_fin      n_fin;
    logic      r_valid_2;
    t_out_item r_out;
    t_out_item n_out;
    logic      round_up;
    t_sat      mul_sat;
    t_sat      div_sat;

    // Ties round away from zero on the magnitude.
    assign round_up = ({i_data.rem, 1'b0} >= {1'b0, i_data.den});

    always_comb begin
        n_fin.common = i_data.common;
        n_fin.q_rnd  = {1'b0, i_data.nq} + {{NUM_W{1'b0}}, round_up};
        n_fin.m_rnd  = {1'b0, i_data.product[PROD_W-1:FRAC_BITS]}
                     + {{(MULQ_W-1){1'b0}}, i_data.product[FRAC_BITS-1]};
    end

    assign mul_sat = sat_mag(r_fin.common.neg, PROD_W'(r_fin.m_rnd));
    assign div_sat = sat_mag(r_fin.common.neg, PROD_W'(r_fin.q_rnd));

    always_comb begin
        n_out.a_greater = r_fin.common.gt;
        n_out.a_equal   = r_fin.common.eq;
        n_out.a_less    = r_fin.common.lt;
        case (r_fin.common.kind)
            KIND_MUL: begin
                n_out.result_value = mul_sat.value;
                n_out.fault        = mul_sat.fault;
            end
            KIND_DIV: begin
                if (r_fin.common.div_zero) begin
                    n_out.result_value = r_fin.common.a_neg ? SAT_MIN : SAT_MAX;
                    n_out.fault        = FAULT_DIV0;
                end else begin
                    n_out.result_value = div_sat.value;
                    n_out.fault        = div_sat.fault;
                end
            end
            default: begin
                n_out.result_value = r_fin.common.simple_result;
                n_out.fault        = r_fin.common.simple_fault;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_1 <= 1'b0;
            r_valid_2 <= 1'b0;
        end else if (i_en) begin
            r_valid_1 <= i_valid;
            r_valid_2 <= r_valid_1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fin <= n_fin;
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid_2;
    assign o_data  = r_out;

endmodule

// File: src/fixed_point_q24_8_alu.sv
// The path is an input stage, a product stage, 40 division cells (one quotient bit each),
// two rounding and saturation stages and an output register backed by a one-entry skid buffer.
// Throughput: one item per cycle; the input stalls only while the skid buffer is full.
// Reset: synchronous, active low; it empties every stage and the output, with no clearing pass.
// The divider chain is one cell per quotient bit, so latency grows with the fraction width.
module fixed_point_q24_8_alu import fpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic      en;
    logic      prep_valid;
    t_prep     prep_data;
    logic      cell_valid [DIV_CELLS+1];
    t_cell     cell_data  [DIV_CELLS+1];
    logic      fin_valid;
    t_out_item fin_data;
    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;
    logic      take;

    // The whole pipeline moves unless the skid buffer already holds a result.
    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;

    fpa_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_item),
        .o_valid (prep_valid),
        .o_data  (prep_data)
    );

    fpa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prep_valid),
        .i_data  (prep_data),
        .o_valid (cell_valid[0]),
        .o_data  (cell_data[0])
    );

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
        fpa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cell_valid[g]),
            .i_data  (cell_data[g]),
            .o_valid (cell_valid[g+1]),
            .o_data  (cell_data[g+1])
        );
    end

    fpa_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cell_valid[DIV_CELLS]),
        .i_data  (cell_data[DIV_CELLS]),
        .o_valid (fin_valid),
        .o_data  (fin_data)
    );

    assign take = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= fin_valid;
            end
        end else if (fin_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= r_skid_valid ? r_skid : fin_data;
        end else if (fin_valid && !r_skid_valid) begin
            r_skid <= fin_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid buffer holds a result while the output register is empty");

    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_item.a_greater, o_item.a_equal, o_item.a_less}))
        else $error("compare flags are not one-hot");

    a_fault_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_item.fault == FAULT_OVF || o_item.fault == FAULT_DIV0))
        |-> (o_item.result_value == SAT_MAX || o_item.result_value == SAT_MIN))
        else $error("faulted result is not saturated");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Q24.8 fixed-point ALU with a valid/stall scoreboard.
module tb;
    import fpa_pkg::*;

    localparam int          RANDOM_ITEMS   = 500;
    localparam int          PRESSURE_AT    = 200;
    localparam int          PRESSURE_BURST = 150;
    localparam int          HOLD_CYCLES    = 200;
    localparam int          DRAIN_CYCLES   = 60;
    localparam int          PRINT_LIMIT    = 40;
    localparam logic [3:0]  KIND_SPARE_LO  = 4'd9;
    localparam logic [3:0]  KIND_SPARE_HI  = 4'd15;

    typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY} t_rx_mode;

    typedef struct {
        t_in_item  op;
        bit        typed;
        t_out_item want;
    } t_directed_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    t_out_item pending_results[$];
    int        mismatch_count;
    int        burst_left;
    bit        hold_request;

    // Typed expectations cover saturation, divide by zero, conversion extremes and spare codes.
    t_directed_row directed_rows [25] = '{
        '{'{KIND_ADD, SAT_MAX, 32'sd1}, 1'b1, '{SAT_MAX, 1'b1, 1'b0, 1'b0, FAULT_OVF}},
        '{'{KIND_ADD, SAT_MIN, -32'sd1}, 1'b1, '{SAT_MIN, 1'b0, 1'b0, 1'b1, FAULT_OVF}},
        '{'{KIND_SUB, SAT_MIN, 32'sd1}, 1'b1, '{SAT_MIN, 1'b0, 1'b0, 1'b1, FAULT_OVF}},
        '{'{KIND_SUB, SAT_MAX, SAT_MIN}, 1'b1, '{SAT_MAX, 1'b1, 1'b0, 1'b0, FAULT_OVF}},
        '{'{KIND_MUL, SAT_MAX, SAT_MAX}, 1'b1, '{SAT_MAX, 1'b0, 1'b1, 1'b0, FAULT_OVF}},
        '{'{KIND_MUL, SAT_MIN, SAT_MIN}, 1'b1, '{SAT_MAX, 1'b0, 1'b1, 1'b0, FAULT_OVF}},
        '{'{KIND_MUL, SAT_MIN, 32'sd256}, 1'b0, '0},
        '{'{KIND_MUL, 32'sd128, 32'sd1}, 1'b0, '0},
        '{'{KIND_MUL, -32'sd128, 32'sd1}, 1'b0, '0},
        '{'{KIND_DIV, 32'sd5, 32'sd0}, 1'b1, '{SAT_MAX, 1'b1, 1'b0, 1'b0, FAULT_DIV0}},
        '{'{KIND_DIV, -32'sd5, 32'sd0}, 1'b1, '{SAT_MIN, 1'b0, 1'b0, 1'b1, FAULT_DIV0}},
        '{'{KIND_DIV, 32'sd0, 32'sd0}, 1'b1, '{SAT_MAX, 1'b0, 1'b1, 1'b0, FAULT_DIV0}},
        '{'{KIND_DIV, SAT_MIN, 32'sd1}, 1'b1, '{SAT_MIN, 1'b0, 1'b0, 1'b1, FAULT_OVF}},
        '{'{KIND_DIV, 32'sd1, 32'sd512}, 1'b0, '0},
        '{'{KIND_DIV, -32'sd1, 32'sd512}, 1'b0, '0},
        '{'{KIND_MIN, SAT_MIN, SAT_MAX}, 1'b0, '0},
        '{'{KIND_MAX, SAT_MIN, SAT_MAX}, 1'b0, '0},
        '{'{KIND_INC, SAT_MAX, 32'sd0}, 1'b1, '{SAT_MAX, 1'b1, 1'b0, 1'b0, FAULT_OVF}},
        '{'{KIND_DEC, SAT_MIN, 32'sd0}, 1'b1, '{SAT_MIN, 1'b0, 1'b0, 1'b1, FAULT_OVF}},
        '{'{KIND_INC, -32'sd1, 32'sd0}, 1'b0, '0},
        '{'{KIND_TO_INT, -32'sd1, -32'sd1}, 1'b1,
          '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, FAULT_NONE}},
        '{'{KIND_TO_INT, SAT_MIN, 32'sd0}, 1'b1,
          '{32'hFF80_0000, 1'b0, 1'b0, 1'b1, FAULT_NONE}},
        '{'{KIND_TO_INT, SAT_MAX, SAT_MAX}, 1'b1,
          '{32'h007F_FFFF, 1'b0, 1'b1, 1'b0, FAULT_NONE}},
        '{'{KIND_SPARE_LO, 32'sd3, 32'sd3}, 1'b1, '{32'd0, 1'b0, 1'b1, 1'b0, FAULT_NONE}},
        '{'{KIND_SPARE_HI, -32'sd1, 32'sd0}, 1'b1, '{32'd0, 1'b0, 1'b0, 1'b1, FAULT_NONE}}
    };

    fixed_point_q24_8_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [DATA_W-1:0] clamp_to_word(input longint v, inout logic [1:0] f);
        if (v > longint'(2147483647)) begin
            f = FAULT_OVF;
            return SAT_MAX;
        end
        if (v < -longint'(2147483647) - longint'(1)) begin
            f = FAULT_OVF;
            return SAT_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] sign_and_clamp(input logic neg, input logic [63:0] mag,
                                                         inout logic [1:0] f);
        logic [63:0] negated;
        negated = ~mag + 64'd1;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                f = FAULT_OVF;
                return SAT_MIN;
            end
            return negated[DATA_W-1:0];
        end
        if (mag > 64'h7FFF_FFFF) begin
            f = FAULT_OVF;
            return SAT_MAX;
        end
        return mag[DATA_W-1:0];
    endfunction

    function automatic t_out_item alu_predict(input t_in_item it);
        t_out_item   r;
        longint      a;
        longint      b;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] quo;
        logic [63:0] rest;
        logic        neg;
        logic [1:0]  f;
        a   = longint'($signed(it.operand_a));
        b   = longint'($signed(it.operand_b));
        ma  = (a < 0) ? 64'(-a) : 64'(a);
        mb  = (b < 0) ? 64'(-b) : 64'(b);
        neg = (a < 0) != (b < 0);
        f   = FAULT_NONE;
        r.a_greater = (a > b);
        r.a_equal   = (a == b);
        r.a_less    = (a < b);
        case (it.kind)
            KIND_ADD: r.result_value = clamp_to_word(a + b, f);
            KIND_SUB: r.result_value = clamp_to_word(a - b, f);
            KIND_MUL: begin
                quo = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                r.result_value = sign_and_clamp(neg, quo, f);
            end
            KIND_DIV: begin
                if (b == 0) begin
                    f = FAULT_DIV0;
                    r.result_value = (a < 0) ? SAT_MIN : SAT_MAX;
                end else begin
                    quo  = (ma << FRAC_BITS) / mb;
                    rest = (ma << FRAC_BITS) % mb;
                    // Ties round away from zero, so the magnitude rounds half up.
                    if (2 * rest >= mb) quo = quo + 64'd1;
                    r.result_value = sign_and_clamp(neg, quo, f);
                end
            end
            KIND_MIN: r.result_value = (a < b) ? it.operand_a : it.operand_b;
            KIND_MAX: r.result_value = (a > b) ? it.operand_a : it.operand_b;
            KIND_INC: r.result_value = clamp_to_word(a + 1, f);
            KIND_DEC: r.result_value = clamp_to_word(a - 1, f);
            KIND_TO_INT: r.result_value = $signed(it.operand_a) >>> FRAC_BITS;
            default: r.result_value = '0;
        endcase
        r.fault = f;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // One transfer: valid is set for each item and held until the block takes it; it drops only between bursts.
    task automatic offer_op(input t_in_item it, input t_out_item want);
        if (burst_left == 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end else begin
            burst_left--;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(want);
    endtask

    function automatic logic [31:0] pick_operand(input bit divisor);
        logic [31:0] v;
        v = $urandom;
        if (divisor && $urandom_range(0, 9) == 0) return '0;
        case ($urandom_range(0, 5))
            0: return v;
            1: return 32'($signed(v[12:0]));
            2: return 32'($signed(v[23:0]));
            3: return {v[31:8], 8'h00};
            4: case (v[2:0])
                   3'd0: return SAT_MAX;
                   3'd1: return SAT_MIN;
                   3'd2: return '0;
                   3'd3: return 32'd1;
                   3'd4: return '1;
                   3'd5: return SAT_MAX - v[7:4];
                   3'd6: return SAT_MIN + v[7:4];
                   default: return 32'd256;
               endcase
            default: return 32'($signed(v[19:0]));
        endcase
    endfunction

    // Receiver: alternates free flow, light and heavy stalling, and one long hold when asked.
    initial begin
        int       span;
        t_rx_mode mode;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end else begin
                span = $urandom_range(5, 40);
                mode = t_rx_mode'($urandom_range(0, 2));
                repeat (span) begin
                    @(negedge i_clk);
                    case (mode)
                        RX_FLOW:  i_stall <= 1'b0;
                        RX_LIGHT: i_stall <= ($urandom_range(0, 2) == 0);
                        default:  i_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing pending", '0, o_item.result_value);
            end else begin
                want = pending_results.pop_front();
                if (o_item.result_value !== want.result_value)
                    flag_mismatch("result_value", want.result_value, o_item.result_value);
                if (o_item.a_greater !== want.a_greater)
                    flag_mismatch("a_greater", 32'(want.a_greater), 32'(o_item.a_greater));
                if (o_item.a_equal !== want.a_equal)
                    flag_mismatch("a_equal", 32'(want.a_equal), 32'(o_item.a_equal));
                if (o_item.a_less !== want.a_less)
                    flag_mismatch("a_less", 32'(want.a_less), 32'(o_item.a_less));
                if (o_item.fault !== want.fault)
                    flag_mismatch("fault", 32'(want.fault), 32'(o_item.fault));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_in_item it;
        int       guard;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_item         = '0;
        mismatch_count = 0;
        burst_left     = 0;
        hold_request   = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            offer_op(directed_rows[k].op, directed_rows[k].typed ? directed_rows[k].want
                                                                 : alu_predict(directed_rows[k].op));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PRESSURE_AT) begin
                // Back-to-back items while the receiver holds off fill the pipeline.
                hold_request = 1'b1;
                burst_left   = PRESSURE_BURST;
            end
            if ($urandom_range(0, 19) < 18)
                it.kind = 4'($urandom_range(KIND_ADD, KIND_TO_INT));
            else
                it.kind = 4'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            it.operand_a = pick_operand(1'b0);
            it.operand_b = pick_operand(it.kind == KIND_DIV);
            offer_op(it, alu_predict(it));
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        guard = 0;
        while (guard < DRAIN_CYCLES) begin
            @(posedge i_clk);
            guard++;
        end

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
